FILE: hdl/ccrr_pkg.sv
// Package with the item types, codes and the CRC-16 byte update for the reply receiver.
`timescale 1ns / 1ps

package ccrr_pkg;

  localparam int CRC_WIDTH  = 16;
  localparam int BYTE_WIDTH = 8;
  localparam int VAL_WIDTH  = 32;
  localparam int POS_WIDTH  = 3;

  localparam logic [CRC_WIDTH-1:0]  CRC_POLY             = 16'h1021;
  localparam logic [CRC_WIDTH-1:0]  CRC_TOP              = 16'h8000;
  localparam logic [BYTE_WIDTH-1:0] DEVICE_ADDRESS_RESET = 8'd128;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  localparam logic [1:0] KIND_U16     = 2'd0;
  localparam logic [1:0] KIND_U32     = 2'd1;
  localparam logic [1:0] KIND_U32_DIR = 2'd2;

  typedef struct packed {
    logic                  func;
    logic [BYTE_WIDTH-1:0] command;
    logic [1:0]            reply_kind;
    logic [BYTE_WIDTH-1:0] data_byte;
  } rx_item_t;

  typedef struct packed {
    logic [VAL_WIDTH-1:0] value;
    logic                 crc_ok;
    logic [CRC_WIDTH-1:0] expected_crc;
    logic [CRC_WIDTH-1:0] received_crc;
  } res_item_t;

  function automatic logic [CRC_WIDTH-1:0] crc_fold(input logic [CRC_WIDTH-1:0] crc,
                                                   input logic [BYTE_WIDTH-1:0] b);
    logic [CRC_WIDTH-1:0] c;
    c = crc ^ {b, {(CRC_WIDTH-BYTE_WIDTH){1'b0}}};
    for (int k = 0; k < BYTE_WIDTH; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_WIDTH-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [CRC_WIDTH-1:0] ADDR_CRC_RESET = crc_fold('0, DEVICE_ADDRESS_RESET);

endpackage

FILE: hdl/ccrr_res_buf.sv
// Two-entry result buffer that lets new bytes be taken while a result waits.
`timescale 1ns / 1ps

module ccrr_res_buf import ccrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  res_item_t push_item,
  output logic      full,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res_item
);

  logic [1:0] count;
  res_item_t  head;
  res_item_t  spare;
  logic       pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign res_item  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            head  <= push_item;
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            head <= push_item;
          end else if (push) begin
            spare <= push_item;
            count <= 2'd2;
          end else if (pop) begin
            count <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            head  <= spare;
            count <= 2'd1;
          end
        end
        default: begin
          count <= 2'd0;
        end
      endcase
    end
  end

endmodule

FILE: hdl/crc_checked_reply_receiver.sv
// Top level of the CRC-checked reply receiver: frame tracking, CRC update and result buffer.
//
//   channel  direction  handshake            payload
//   rx       in         rx_valid / rx_stall  rx_item (rx_item_t)
//   res      out        res_valid / res_stall res_item (res_item_t)
//   cfg      in         cfg_valid / cfg_ready cfg_data (device address)
//
// The CRC byte update and value gathering sit between the accepted item and the frame
// registers, and a result enters the buffer on the same edge.
// A result is registered into the result buffer when the last CRC byte is transferred,
// and reaches res later when an earlier result is still waiting in the buffer.
// Reset ends any frame in progress and sets the device address to 128.
// rx stalls only while both result buffer entries are waiting; cfg_ready is always high.
`timescale 1ns / 1ps

module crc_checked_reply_receiver import ccrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  output logic                  rx_stall,
  input  rx_item_t              rx_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [BYTE_WIDTH-1:0] cfg_data
);

  logic [CRC_WIDTH-1:0]  addr_crc;
  logic [CRC_WIDTH-1:0]  running_crc;
  logic [VAL_WIDTH-1:0]  value_accumulator;
  logic [POS_WIDTH-1:0]  byte_position;
  logic [1:0]            pending_kind;
  logic                  reply_pending;
  logic [BYTE_WIDTH-1:0] crc_high_byte;

  logic                  rx_accept;
  logic                  buf_full;
  logic                  push;
  res_item_t             push_item;
  logic [POS_WIDTH-1:0]  value_bytes;
  logic [POS_WIDTH-1:0]  payload_bytes;
  logic [CRC_WIDTH-1:0]  crc_byte_next;
  logic [CRC_WIDTH-1:0]  received;

  assign cfg_ready = 1'b1;
  assign rx_stall  = buf_full;
  assign rx_accept = rx_valid && !rx_stall;

  assign value_bytes   = (pending_kind == KIND_U16) ? POS_WIDTH'(2) : POS_WIDTH'(4);
  assign payload_bytes = (pending_kind == KIND_U32_DIR) ? POS_WIDTH'(5) : value_bytes;
  assign crc_byte_next = crc_fold(running_crc, rx_item.data_byte);
  assign received      = {crc_high_byte, rx_item.data_byte};

  assign push = rx_accept && (rx_item.func == FUNC_BYTE) && reply_pending
             && (byte_position > payload_bytes);

  always_comb begin
    push_item.value        = value_accumulator;
    push_item.crc_ok       = (received == running_crc);
    push_item.expected_crc = running_crc;
    push_item.received_crc = received;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_crc <= ADDR_CRC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      addr_crc <= crc_fold('0, cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_pending <= 1'b0;
      byte_position <= '0;
    end else if (rx_accept) begin
      if (rx_item.func == FUNC_START) begin
        running_crc       <= crc_fold(addr_crc, rx_item.command);
        value_accumulator <= '0;
        byte_position     <= '0;
        crc_high_byte     <= '0;
        pending_kind      <= rx_item.reply_kind;
        reply_pending     <= (rx_item.reply_kind <= KIND_U32_DIR);
      end else if (reply_pending) begin
        if (byte_position < value_bytes) begin
          value_accumulator <= {value_accumulator[VAL_WIDTH-BYTE_WIDTH-1:0],
                                rx_item.data_byte};
          running_crc       <= crc_byte_next;
          byte_position     <= byte_position + POS_WIDTH'(1);
        end else if (byte_position < payload_bytes) begin
          running_crc <= crc_byte_next;
          if (rx_item.data_byte != '0) begin
            value_accumulator <= '0 - value_accumulator;
          end
          byte_position <= byte_position + POS_WIDTH'(1);
        end else if (byte_position == payload_bytes) begin
          crc_high_byte <= rx_item.data_byte;
          byte_position <= byte_position + POS_WIDTH'(1);
        end else begin
          reply_pending <= 1'b0;
          byte_position <= '0;
        end
      end
    end
  end

  ccrr_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (buf_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid)
    else $error("rx stalled with no result waiting");

  a_push_ends_frame: assert property (@(posedge clk) disable iff (rst)
    push |=> !reply_pending)
    else $error("frame still pending after its result");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_WIDTH'(6))
    else $error("byte position beyond the longest frame");

  a_result_after_push: assert property (@(posedge clk) disable iff (rst)
    push |=> res_valid)
    else $error("result lost after push");

endmodule

FILE: tb/tb_crc_checked_reply_receiver.sv
// Testbench for the CRC-checked reply receiver with frame predictor and reply scoreboard.
`timescale 1ns / 1ps

module tb_crc_checked_reply_receiver;
  import ccrr_pkg::*;

  class reply_scoreboard;
    logic [7:0]  dev_addr;
    logic [15:0] crc_acc;
    logic [31:0] value_acc;
    int unsigned pos;
    logic [1:0]  frame_kind;
    bit          in_frame;
    logic [7:0]  crc_hi;
    res_item_t   replies[$];
    int          errors;

    function new();
      dev_addr   = DEVICE_ADDRESS_RESET;
      crc_acc    = '0;
      value_acc  = '0;
      pos        = 0;
      frame_kind = KIND_U16;
      in_frame   = 1'b0;
      crc_hi     = '0;
      errors     = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void set_address(logic [7:0] a);
      dev_addr = a;
    endfunction

    function void predict_reply(rx_item_t it);
      int unsigned value_len;
      int unsigned body_len;
      res_item_t   r;
      if (it.func == FUNC_START) begin
        crc_acc    = crc_step(crc_step(16'h0000, dev_addr), it.command);
        value_acc  = '0;
        pos        = 0;
        crc_hi     = '0;
        frame_kind = it.reply_kind;
        in_frame   = (it.reply_kind == KIND_U16) || (it.reply_kind == KIND_U32) ||
                     (it.reply_kind == KIND_U32_DIR);
        return;
      end
      if (!in_frame) return;
      value_len = (frame_kind == KIND_U16) ? 2 : 4;
      body_len  = (frame_kind == KIND_U32_DIR) ? 5 : value_len;
      if (pos < value_len) begin
        value_acc = {value_acc[23:0], it.data_byte};
        crc_acc   = crc_step(crc_acc, it.data_byte);
      end else if (pos < body_len) begin
        crc_acc = crc_step(crc_acc, it.data_byte);
        if (it.data_byte != 8'h00) value_acc = 32'd0 - value_acc;
      end else if (pos == body_len) begin
        crc_hi = it.data_byte;
      end else begin
        r.value        = value_acc;
        r.received_crc = {crc_hi, it.data_byte};
        r.expected_crc = crc_acc;
        r.crc_ok       = (r.received_crc == crc_acc);
        replies.push_back(r);
        in_frame = 1'b0;
        pos      = 0;
        return;
      end
      pos++;
    endfunction

    function void check_reply(res_item_t got);
      res_item_t want;
      if (replies.size() == 0) begin
        $error("unexpected reply: value %h crc_ok %b expected_crc %h received_crc %h",
               got.value, got.crc_ok, got.expected_crc, got.received_crc);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        errors++;
      end
      if (got.crc_ok !== want.crc_ok) begin
        $error("crc_ok: expected %b, got %b", want.crc_ok, got.crc_ok);
        errors++;
      end
      if (got.expected_crc !== want.expected_crc) begin
        $error("expected_crc: expected %h, got %h", want.expected_crc, got.expected_crc);
        errors++;
      end
      if (got.received_crc !== want.received_crc) begin
        $error("received_crc: expected %h, got %h", want.received_crc, got.received_crc);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_stall;
  rx_item_t  rx_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  reply_scoreboard sb;
  bit brisk = 1'b0;
  bit hold_request = 1'b0;
  int unsigned frame_items = 0;

  crc_checked_reply_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_item(rx_item_t it);
    int unsigned gap;
    gap = brisk ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_item  <= it;
    do @(posedge clk); while (rx_stall);
    sb.predict_reply(it);
  endtask

  task automatic send_start(logic [1:0] kind, logic [7:0] cmd);
    rx_item_t it;
    it.func       = FUNC_START;
    it.command    = cmd;
    it.reply_kind = kind;
    it.data_byte  = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    rx_item_t it;
    it.func       = FUNC_BYTE;
    it.command    = 8'($urandom);
    it.reply_kind = 2'($urandom_range(0, 3));
    it.data_byte  = b;
    send_item(it);
  endtask

  // A negative or oversized cut sends all of the frame, else just the first cut bytes.
  task automatic send_frame(logic [1:0] kind, logic [7:0] cmd, bit corrupt, bit ones, int cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          len;
    send_start(kind, cmd);
    crc = reply_scoreboard::crc_step(reply_scoreboard::crc_step(16'h0000, sb.dev_addr), cmd);
    len = (kind == KIND_U16) ? 2 : 4;
    for (int i = 0; i < len; i++) begin
      b = ones ? 8'hFF : 8'($urandom);
      body.push_back(b);
      crc = reply_scoreboard::crc_step(crc, b);
    end
    if (kind == KIND_U32_DIR) begin
      if (ones) b = 8'hFF;
      else b = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00;
      body.push_back(b);
      crc = reply_scoreboard::crc_step(crc, b);
    end
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 65535));
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    if (cut < 0 || cut > body.size()) cut = body.size();
    for (int i = 0; i < cut; i++) send_byte(body[i]);
    frame_items += 1 + cut;
  endtask

  task automatic wait_for_replies();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_address(a);
  endtask

  task automatic random_traffic(int unsigned count, bit pause_midway);
    int unsigned target;
    int unsigned r;
    logic [1:0]  kind;
    bit          paused;
    target = frame_items + count;
    paused = 1'b0;
    while (frame_items < target) begin
      if ($urandom_range(0, 19) == 0) brisk = !brisk;
      if (pause_midway && !paused && frame_items >= target - count / 2) begin
        wait_for_replies();
        paused = 1'b1;
      end
      r    = $urandom_range(0, 99);
      kind = 2'($urandom_range(0, 2));
      if (r < 70) begin
        send_frame(kind, 8'($urandom), 1'b0, 1'b0, -1);
      end else if (r < 82) begin
        send_frame(kind, 8'($urandom), 1'b1, 1'b0, -1);
      end else if (r < 90) begin
        send_frame(kind, 8'($urandom), $urandom_range(0, 1), 1'b0, $urandom_range(0, 6));
      end else if (r < 95) begin
        send_start(2'd3, 8'($urandom));
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
    brisk = 1'b0;
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) begin
        sb.check_reply(res_item);
        if (hold_request) begin
          hold = 400;
          hold_request = 1'b0;
        end else begin
          hold = brisk ? 0 : $urandom_range(0, 12);
        end
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[crc_checked_reply_receiver] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hA5);
    send_start(2'd3, 8'h11);
    send_byte(8'h3C);
    send_frame(KIND_U16, 8'h22, 1'b0, 1'b0, 1);
    send_frame(KIND_U16, 8'h00, 1'b0, 1'b1, -1);
    send_frame(KIND_U32_DIR, 8'hFF, 1'b0, 1'b1, -1);
    send_frame(KIND_U32, 8'h80, 1'b1, 1'b0, -1);
    wait_for_replies();

    write_address(8'h00);
    hold_request = 1'b1;
    random_traffic(350, 1'b0);
    wait_for_replies();

    write_address(8'hFF);
    random_traffic(350, 1'b1);
    wait_for_replies();

    write_address(8'($urandom));
    random_traffic(350, 1'b0);
    wait_for_replies();

    write_address(DEVICE_ADDRESS_RESET);
    random_traffic(350, 1'b0);
    wait_for_replies();

    if (sb.errors == 0 && sb.replies.size() == 0) begin
      $display("[crc_checked_reply_receiver] OK");
    end else begin
      $display("[crc_checked_reply_receiver] ERROR");
    end
    $finish;
  end

endmodule
